>>> sv/sli_pkg.sv
// Shared types and constants for the sorted list core.
// Used by sli_cell, sli_chain and sorted_list_insert_delete_core; no dependencies.
package sli_pkg;

	localparam int DATA_W    = 32;
	localparam int POS_W     = 7;
	localparam int OUT_W     = 8;
	localparam int DEPTH_DEF = 128;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// broadcast to every cell during the execute cycle
	typedef struct packed {
		logic              ins_en;
		logic              del_en;
		logic [DATA_W-1:0] value;
		logic [POS_W-1:0]  pos;
	} cell_ctrl_t;

endpackage

>>> sv/sli_cell.sv
// One cell of the sorted list: holds one entry and decides its own update
// from its neighbors. Depends on sli_pkg.
module sli_cell #(
	parameter int IDX = 0,
	parameter int CW  = 8
) (
	input  logic                      clk,
	input  sli_pkg::cell_ctrl_t       ctrl,
	input  logic [CW-1:0]             fill,
	input  logic [sli_pkg::DATA_W-1:0] prev_entry,
	input  logic                      prev_gt,
	input  logic [sli_pkg::DATA_W-1:0] next_entry,
	output logic [sli_pkg::DATA_W-1:0] entry,
	output logic                      gt,
	output logic                      take,
	output logic [sli_pkg::DATA_W-1:0] rd
);
	import sli_pkg::*;

	localparam logic [CW-1:0]       IDX_C  = CW'(IDX);
	localparam logic [CW+POS_W-1:0] IDX_CP = (CW+POS_W)'(IDX);

	logic [DATA_W-1:0] entry_q;
	logic              valid;
	logic              at_end;
	logic              past_pos;
	logic              hit;
	logic              move_down;

	assign valid    = IDX_C < fill;
	assign at_end   = IDX_C == fill;
	assign gt       = valid && ($signed(ctrl.value) < $signed(entry_q));
	// first greater entry, or the first free slot when nothing is greater
	assign take     = valid ? (gt && !prev_gt) : (at_end && !prev_gt);
	assign past_pos = IDX_CP >= {{CW{1'b0}}, ctrl.pos};
	assign hit      = IDX_CP == {{CW{1'b0}}, ctrl.pos};
	assign move_down = past_pos && ((IDX_CP + 1'b1) < {{POS_W{1'b0}}, fill});
	assign rd       = (hit && valid) ? entry_q : '0;
	assign entry    = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins_en && (valid || at_end)) begin
			if (prev_gt) begin
				entry_q <= prev_entry;
			end else if (take) begin
				entry_q <= ctrl.value;
			end
		end else if (ctrl.del_en && move_down) begin
			entry_q <= next_entry;
		end
	end

endmodule

>>> sv/sli_chain.sv
// Row of sli_cell instances with the insertion-index encoder and read-out.
// Depends on sli_pkg and sli_cell.
module sli_chain #(
	parameter int DEPTH = sli_pkg::DEPTH_DEF,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                       clk,
	input  sli_pkg::cell_ctrl_t        ctrl,
	input  logic [CW-1:0]              fill,
	output logic                       any_take,
	output logic [CW-1:0]              at_idx,
	output logic [sli_pkg::DATA_W-1:0] rd_value
);
	import sli_pkg::*;

	logic [DATA_W-1:0] entry_w [DEPTH];
	logic [DATA_W-1:0] rd_w    [DEPTH];
	logic [DEPTH-1:0]  gt_w;
	logic [DEPTH-1:0]  take_w;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] prev_e;
		logic [DATA_W-1:0] next_e;
		logic              prev_g;

		if (i == 0) begin : g_first
			assign prev_e = '0;
			assign prev_g = 1'b0;
		end else begin : g_mid
			assign prev_e = entry_w[i-1];
			assign prev_g = gt_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_e = '0;
		end else begin : g_nlast
			assign next_e = entry_w[i+1];
		end

		sli_cell #(
			.IDX(i),
			.CW (CW)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.fill      (fill),
			.prev_entry(prev_e),
			.prev_gt   (prev_g),
			.next_entry(next_e),
			.entry     (entry_w[i]),
			.gt        (gt_w[i]),
			.take      (take_w[i]),
			.rd        (rd_w[i])
		);
	end

	// at most one cell takes and at most one cell hits, so OR the results
	always_comb begin
		at_idx   = '0;
		rd_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (take_w[i]) begin
				at_idx = at_idx | CW'(i);
			end
			rd_value = rd_value | rd_w[i];
		end
	end

	assign any_take = |take_w;

endmodule

>>> sv/sorted_list_insert_delete_core.sv
// Sorted list core: input register, row of compare/shift cells and result register.
// Depends on sli_pkg, sli_chain and sli_cell.
//
// Usage:
//   Input items arrive on s_t*: s_tuser carries the command (insert, delete,
//   read), s_tdata the value to insert and the position to delete or read.
//   Every item yields exactly one result item on m_t*: m_tuser carries the
//   status, m_tdata the read value, the index acted on and the new length.
//   All entries compare against the value in parallel, each cell choosing
//   locally to keep, take the new value or copy a neighbor, so the list is
//   updated in the execute cycle.
//   An accepted item waits in the input register, is executed into the output
//   register and shows on m_tvalid, where it holds until the receiver takes it.
//   One item is accepted every cycle while the receiver keeps up, since the
//   execute cycle leaves the list ready for the next item's compare.
//   When the receiver stalls the result holds in the output register and one
//   more item waits in the input register; s_tready then drops.
//   Reset empties the list at once (length zero); stored words need no clearing.
module sorted_list_insert_delete_core #(
	parameter int DEPTH = sli_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value[31:0], position[38:32], zero[39]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // read_value[31:0], where[39:32], count[47:40]
	output logic [1:0]  m_tuser    // status[1:0]
);
	import sli_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic              valid_s1;
	logic [1:0]        cmd_s1;
	logic [DATA_W-1:0] value_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [CW-1:0]     fill_q;

	logic              m_valid_q;
	logic [1:0]        status_q;
	logic [DATA_W-1:0] rd_q;
	logic [OUT_W-1:0]  where_q;
	logic [OUT_W-1:0]  count_q;

	logic              out_free;
	logic              exec;
	logic              full;
	logic              pos_ok;
	cell_ctrl_t        ctrl;
	logic              any_take;
	logic [CW-1:0]     at_idx;
	logic [DATA_W-1:0] rd_value;

	logic [1:0]        status_d;
	logic [DATA_W-1:0] rd_d;
	logic [CW+POS_W-1:0] where_d;
	logic [CW-1:0]     fill_d;
	logic [CW+POS_W+OUT_W-1:0] where_ext;
	logic [CW+OUT_W-1:0] fill_ext;

	assign out_free = !m_valid_q || m_tready;
	assign exec     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	assign full   = fill_q == DEPTH_C;
	assign pos_ok = {{CW{1'b0}}, pos_s1} < {{POS_W{1'b0}}, fill_q};

	assign ctrl.ins_en = exec && (cmd_s1 == CMD_INSERT) && !full;
	assign ctrl.del_en = exec && (cmd_s1 == CMD_DELETE) && pos_ok;
	assign ctrl.value  = value_s1;
	assign ctrl.pos    = pos_s1;

	sli_chain #(
		.DEPTH(DEPTH),
		.CW   (CW)
	) u_chain (
		.clk     (clk),
		.ctrl    (ctrl),
		.fill    (fill_q),
		.any_take(any_take),
		.at_idx  (at_idx),
		.rd_value(rd_value)
	);

	always_comb begin
		status_d = ST_DONE;
		rd_d     = '0;
		where_d  = {{CW{1'b0}}, pos_s1};
		fill_d   = fill_q;
		case (cmd_s1)
			CMD_INSERT: begin
				where_d = {{POS_W{1'b0}}, (any_take ? at_idx : fill_q)};
				if (full) begin
					status_d = ST_FULL;
				end else begin
					fill_d = fill_q + 1'b1;
				end
			end
			CMD_DELETE: begin
				if (!pos_ok) begin
					status_d = ST_RANGE;
				end else begin
					fill_d = fill_q - 1'b1;
				end
			end
			CMD_READ: begin
				if (!pos_ok) begin
					status_d = ST_RANGE;
				end else begin
					rd_d = rd_value;
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	// where and count wrap to eight bits for deep lists
	assign where_ext = {{OUT_W{1'b0}}, where_d};
	assign fill_ext  = {{OUT_W{1'b0}}, fill_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			fill_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (exec) begin
				fill_q <= fill_d;
			end
			if (out_free) begin
				m_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1   <= s_tuser;
			value_s1 <= s_tdata[31:0];
			pos_s1   <= s_tdata[38:32];
		end
		if (exec) begin
			status_q <= status_d;
			rd_q     <= rd_d;
			where_q  <= where_ext[OUT_W-1:0];
			count_q  <= fill_ext[OUT_W-1:0];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {count_q, where_q, rd_q};
	assign m_tuser  = status_q;

endmodule

>>> sim/sorted_list_insert_delete_core_tb.sv
// Self-checking bench for sorted_list_insert_delete_core: streams insert, delete and read items
// with random idling on both sides and checks every result against an in-bench list model.
// Depends on sli_pkg and the core RTL.
module sorted_list_insert_delete_core_tb;
	import sli_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int ITEMS       = 1600;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef enum logic [1:0] {PH_FILL, PH_MIXED, PH_DRAIN} phase_t;

	typedef struct packed {
		logic [3:0]  gap;
		logic [1:0]  op;
		logic [31:0] value;
		logic [6:0]  pos;
	} list_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] read_value;
		logic [7:0]  where;
		logic [7:0]  count;
	} list_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;   // value[31:0], position[38:32], zero[39]
	logic [1:0]  s_tuser  = '0;   // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;         // read_value[31:0], where[39:32], count[47:40]
	logic [1:0]  m_tuser;         // status[1:0]

	list_req_t    pending[$];
	list_result_t results_due[$];

	// list model state
	logic signed [31:0] held[DEPTH];
	int held_len = 0;

	int  cycles = 0;
	int  mismatches = 0;
	int  checked = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	bit  in_taken = 1'b0;
	int  len_est = 0;
	int  n_gen = 0;
	int  n_ins = 0, n_full = 0, n_del = 0, n_read = 0, n_range = 0, n_unused = 0;
	int  peak_len = 0;

	sorted_list_insert_delete_core #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Apply one command to the list model and queue the result it must produce.
	task automatic apply_list_op(input logic [1:0] op, input logic signed [31:0] val,
			input logic [6:0] pos);
		list_result_t r;
		int at;
		int i;
		r.status     = ST_DONE;
		r.read_value = '0;
		r.where      = {1'b0, pos};
		case (op)
			CMD_INSERT: begin
				at = held_len;
				// first entry strictly greater wins; equal values stay in arrival order
				for (i = held_len - 1; i >= 0; i--)
					if (val < held[i])
						at = i;
				r.where = at[7:0];
				if (held_len >= DEPTH) begin
					r.status = ST_FULL;
					n_full++;
				end else begin
					for (i = held_len; i > at; i--)
						held[i] = held[i - 1];
					held[at] = val;
					held_len++;
				end
				n_ins++;
			end
			CMD_DELETE: begin
				if (pos >= held_len) begin
					r.status = ST_RANGE;
					n_range++;
				end else begin
					for (i = pos; i + 1 < held_len; i++)
						held[i] = held[i + 1];
					held_len--;
				end
				n_del++;
			end
			CMD_READ: begin
				if (pos >= held_len) begin
					r.status = ST_RANGE;
					n_range++;
				end else begin
					r.read_value = held[pos];
				end
				n_read++;
			end
			default: n_unused++;
		endcase
		if (held_len > peak_len)
			peak_len = held_len;
		r.count = held_len[7:0];
		results_due.push_back(r);
	endtask

	task automatic note_mismatch(input list_result_t want, input list_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on result %0d: expected status %0d value %h where %0d count %0d,",
				checked, want.status, want.read_value, want.where, want.count,
				" got status %0d value %h where %0d count %0d",
				got.status, got.read_value, got.where, got.count);
	endtask

	// Queue one item; the generator keeps only a length estimate to aim positions.
	task automatic queue_req(input logic [1:0] op, input logic [31:0] value,
			input logic [6:0] pos);
		list_req_t req;
		req.op    = op;
		req.value = value;
		req.pos   = pos;
		req.gap   = '0;
		if (((n_gen / 150) % 5 != 2) && (n_gen < ITEMS - 150) && ($urandom_range(0, 5) == 0))
			req.gap = 4'($urandom_range(1, 12));
		if (op == CMD_INSERT && len_est < DEPTH)
			len_est++;
		else if (op == CMD_DELETE && pos < len_est)
			len_est--;
		pending.push_back(req);
		n_gen++;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000 + $urandom_range(0, 2);
			1:       return 32'h7FFF_FFFF - $urandom_range(0, 2);
			2, 3, 4: return $urandom_range(0, 15) - 8;   // small spread makes duplicates
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [6:0] pick_pos(input int len);
		int r;
		r = $urandom_range(0, 19);
		if (len > 0 && r < 14)
			return 7'($urandom_range(0, len - 1));
		case (r)
			14:      return 7'(len);
			15:      return (len > 0) ? 7'(len - 1) : 7'd0;
			16, 17:  return 7'($urandom_range(0, 127));
			default: return 7'd0;
		endcase
	endfunction

	function automatic logic [1:0] pick_op(input phase_t kind);
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return CMD_UNUSED;
		case (kind)
			PH_FILL:  return (r < 80) ? CMD_INSERT : (r < 90) ? CMD_READ : CMD_DELETE;
			PH_DRAIN: return (r < 15) ? CMD_INSERT : (r < 35) ? CMD_READ : CMD_DELETE;
			default:  return (r < 40) ? CMD_INSERT : (r < 70) ? CMD_READ : CMD_DELETE;
		endcase
	endfunction

	// source side: present the next item once the current one is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_taken) begin
				if (gap_left > 0) begin
					s_tvalid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {1'b0, pending[0].pos, pending[0].value};
					s_tuser  <= pending[0].op;
					gap_left <= pending[0].gap;
					void'(pending.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink side: random stall bursts, none in calm windows or near the end
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				m_tready   <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				m_tready <= 1'b1;
				if (pending.size() >= 150 && ((cycles / 500) % 4 != 3) &&
						$urandom_range(0, 6) == 0)
					stall_left <= $urandom_range(1, 12);
			end
		end
	end

	always @(posedge clk) begin : monitor
		list_result_t got;
		list_result_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[31:0], m_tdata[39:32], m_tdata[47:40]};
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: status %0d value %h where %0d count %0d",
							got.status, got.read_value, got.where, got.count);
				end else begin
					want = results_due.pop_front();
					if (got != want)
						note_mismatch(want, got);
				end
				checked++;
			end
			in_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				apply_list_op(s_tuser, s_tdata[31:0], s_tdata[38:32]);
		end
	end

	initial begin
		phase_t plan[4];
		int     plan_len[4];
		int     p;
		int     k;
		logic [1:0] op;

		plan     = '{PH_FILL, PH_MIXED, PH_DRAIN, PH_MIXED};
		plan_len = '{260, 150, 300, 120};

		// empty list: reads and deletes out of range
		queue_req(CMD_READ, $urandom, 7'd0);
		queue_req(CMD_DELETE, $urandom, 7'd0);
		queue_req(CMD_DELETE, $urandom, 7'd127);
		// extremes and equal values
		queue_req(CMD_INSERT, 32'h0000_0000, 7'd127);
		queue_req(CMD_INSERT, 32'h7FFF_FFFF, 7'd0);
		queue_req(CMD_INSERT, 32'h8000_0000, 7'd0);
		queue_req(CMD_INSERT, 32'hFFFF_FFFF, 7'd64);
		queue_req(CMD_INSERT, 32'h0000_0000, 7'd0);
		queue_req(CMD_INSERT, 32'h0000_0001, 7'd0);
		for (k = 0; k < 6; k++)
			queue_req(CMD_READ, 32'h0, 7'(k));
		// just past the end, far past the end, unused command
		queue_req(CMD_READ, 32'h0, 7'd6);
		queue_req(CMD_READ, 32'h0, 7'd127);
		queue_req(CMD_UNUSED, $urandom, 7'd5);
		// drop last, first, middle
		queue_req(CMD_DELETE, 32'h0, 7'd5);
		queue_req(CMD_DELETE, 32'h0, 7'd0);
		queue_req(CMD_DELETE, 32'h0, 7'd1);
		queue_req(CMD_READ, 32'h0, 7'd0);

		p = 0;
		while (n_gen < ITEMS) begin
			for (k = 0; k < plan_len[p % 4] && n_gen < ITEMS; k++) begin
				op = pick_op(plan[p % 4]);
				queue_req(op, (op == CMD_INSERT) ? pick_value() : $urandom,
					(op == CMD_INSERT || op == CMD_UNUSED) ? 7'($urandom_range(0, 127))
						: pick_pos(len_est));
			end
			p++;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending.size() > 0 || s_tvalid)
			@(posedge clk);
		while (results_due.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		mismatches += results_due.size();

		$display("ran %0d inserts (%0d into a full list), %0d deletes, %0d reads, %0d unused",
			n_ins, n_full, n_del, n_read, n_unused);
		$display("%0d out-of-range positions, peak length %0d, %0d results checked, %0d bad",
			n_range, peak_len, checked, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
